### sv/mvsf_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and value compare functions of the memory value scan filter
package mvsf_pkg;

	localparam int PAGE_SIZE_DEF = 4096;
	localparam int STEP_W        = 13;
	localparam int OFFSET_W      = 12;
	localparam int VAL_W         = 64;
	localparam int CFG_ADDR_W    = 6;
	localparam int CFG_DATA_W    = 64;

	localparam logic [2:0] REG_WIDTH_CODE   = 3'd0;
	localparam logic [2:0] REG_TARGET       = 3'd1;
	localparam logic [2:0] REG_INITIAL_MODE = 3'd2;
	localparam logic [2:0] REG_RECHECK_MODE = 3'd3;
	localparam logic [2:0] REG_SCAN_STEP    = 3'd4;

	localparam logic [1:0] WIDTH_1B = 2'd0;
	localparam logic [1:0] WIDTH_2B = 2'd1;
	localparam logic [1:0] WIDTH_4B = 2'd2;
	localparam logic [1:0] WIDTH_8B = 2'd3;

	localparam logic [1:0] INIT_EQ = 2'd0;
	localparam logic [1:0] INIT_GT = 2'd1;
	localparam logic [1:0] INIT_LT = 2'd2;

	localparam logic [2:0] RECHK_EQ   = 3'd0;
	localparam logic [2:0] RECHK_CHG  = 3'd1;
	localparam logic [2:0] RECHK_GT   = 3'd2;
	localparam logic [2:0] RECHK_LT   = 3'd3;
	localparam logic [2:0] RECHK_INC  = 3'd4;
	localparam logic [2:0] RECHK_DEC  = 3'd5;

	localparam logic CMD_SCAN    = 1'b0;
	localparam logic CMD_RECHECK = 1'b1;

	localparam logic KIND_MATCH   = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef struct packed {
		logic [1:0]        width_code;
		logic [VAL_W-1:0]  target;
		logic [1:0]        initial_mode;
		logic [2:0]        recheck_mode;
		logic [STEP_W-1:0] scan_step;
	} cfg_t;

	typedef struct packed {
		logic                kind;
		logic [VAL_W-1:0]    page;
		logic [OFFSET_W-1:0] offset;
		logic [VAL_W-1:0]    value;
		logic                keep;
	} result_t;

	typedef struct packed {
		logic out_valid;
		logic skid_valid;
	} buf_status_t;

	function automatic logic [3:0] width_bytes(input logic [1:0] code);
		width_bytes = 4'd1 << code;
	endfunction

	function automatic logic [VAL_W-1:0] width_mask(input logic [1:0] code);
		case (code)
			WIDTH_1B: width_mask = {{56{1'b0}}, {8{1'b1}}};
			WIDTH_2B: width_mask = {{48{1'b0}}, {16{1'b1}}};
			WIDTH_4B: width_mask = {{32{1'b0}}, {32{1'b1}}};
			default:  width_mask = {VAL_W{1'b1}};
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] sext_value(input logic [VAL_W-1:0] v,
			input logic [1:0] code);
		case (code)
			WIDTH_1B: sext_value = {{56{v[7]}}, v[7:0]};
			WIDTH_2B: sext_value = {{48{v[15]}}, v[15:0]};
			WIDTH_4B: sext_value = {{32{v[31]}}, v[31:0]};
			default:  sext_value = v;
		endcase
	endfunction

	function automatic logic vals_equal(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b, input logic [1:0] code);
		vals_equal = ((a ^ b) & width_mask(code)) == '0;
	endfunction

	function automatic logic val_greater(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b, input logic [1:0] code);
		val_greater = $signed(sext_value(a, code)) > $signed(sext_value(b, code));
	endfunction

endpackage

### sv/mvsf_cfg.sv
`timescale 1ns / 1ps
// apb configuration registers of the memory value scan filter
module mvsf_cfg import mvsf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t        cfg_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_code   <= WIDTH_4B;
			cfg_q.target       <= '0;
			cfg_q.initial_mode <= INIT_EQ;
			cfg_q.recheck_mode <= RECHK_EQ;
			cfg_q.scan_step    <= STEP_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_WIDTH_CODE:   cfg_q.width_code   <= pwdata[1:0];
				REG_TARGET:       cfg_q.target       <= pwdata[VAL_W-1:0];
				REG_INITIAL_MODE: cfg_q.initial_mode <= pwdata[1:0];
				REG_RECHECK_MODE: cfg_q.recheck_mode <= pwdata[2:0];
				REG_SCAN_STEP:    cfg_q.scan_step    <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIDTH_CODE:   prdata = CFG_DATA_W'(cfg_q.width_code);
			REG_TARGET:       prdata = CFG_DATA_W'(cfg_q.target);
			REG_INITIAL_MODE: prdata = CFG_DATA_W'(cfg_q.initial_mode);
			REG_RECHECK_MODE: prdata = CFG_DATA_W'(cfg_q.recheck_mode);
			REG_SCAN_STEP:    prdata = CFG_DATA_W'(cfg_q.scan_step);
			default:          prdata = '0;
		endcase
	end

endmodule

### sv/mvsf_scan.sv
`timescale 1ns / 1ps
// byte window, page position and candidate tracking with the scan compare
module mvsf_scan import mvsf_pkg::*; #(
	parameter int PAGE_SIZE = PAGE_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             end_of_page,
	input  logic [VAL_W-1:0] page_base,
	input  cfg_t             cfg,
	output logic             found,
	output result_t          res
);

	localparam int POS_W  = $clog2(PAGE_SIZE);
	localparam int CAND_W = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
	localparam int LAST_W = CAND_W + 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAGE_SIZE - 1);

	logic [VAL_W-1:0]  win_q;
	logic [POS_W-1:0]  pos_q;
	logic [CAND_W-1:0] cand_q;

	logic [VAL_W-1:0]  win_next;
	logic [VAL_W-1:0]  value;
	logic [3:0]        wbytes;
	logic [STEP_W-1:0] step;
	logic [LAST_W-1:0] last;
	logic [LAST_W-1:0] pos_ext;
	logic              hit;
	logic              restart;
	logic [CAND_W-1:0] cand_next;

	always_comb begin
		win_next = {data_byte, win_q[VAL_W-1:8]};
		wbytes   = width_bytes(cfg.width_code);
		step     = (cfg.scan_step == '0) ? STEP_W'(1) : cfg.scan_step;
		last     = LAST_W'(cand_q) + LAST_W'(wbytes) - LAST_W'(1);
		pos_ext  = LAST_W'(pos_q);
		case (cfg.width_code)
			WIDTH_1B: value = {56'd0, win_next[63:56]};
			WIDTH_2B: value = {48'd0, win_next[63:48]};
			WIDTH_4B: value = {32'd0, win_next[63:32]};
			default:  value = win_next;
		endcase
		case (cfg.initial_mode)
			INIT_EQ: hit = vals_equal(value, cfg.target, cfg.width_code);
			INIT_GT: hit = val_greater(value, cfg.target, cfg.width_code);
			INIT_LT: hit = val_greater(cfg.target, value, cfg.width_code);
			default: hit = 1'b0;
		endcase
		cand_next = cand_q;
		if (pos_ext > last) begin
			cand_next = CAND_W'(pos_q) + CAND_W'(1);
		end else if (pos_ext == last) begin
			if (hit) begin
				cand_next = cand_q + CAND_W'(wbytes) + CAND_W'(step);
			end else begin
				cand_next = cand_q + CAND_W'(step);
			end
		end
		found   = (pos_ext == last) && hit;
		restart = end_of_page || (pos_q == POS_LAST);

		res.kind   = KIND_MATCH;
		res.page   = page_base;
		res.offset = cand_q[OFFSET_W-1:0];
		res.value  = value;
		res.keep   = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			pos_q  <= '0;
			cand_q <= '0;
		end else if (accept) begin
			if (restart) begin
				win_q  <= '0;
				pos_q  <= '0;
				cand_q <= '0;
			end else begin
				win_q  <= win_next;
				pos_q  <= pos_q + POS_W'(1);
				cand_q <= cand_next;
			end
		end
	end

endmodule

### sv/mvsf_recheck.sv
`timescale 1ns / 1ps
// keep or drop verdict for one stored entry
module mvsf_recheck import mvsf_pkg::*; (
	input  logic [VAL_W-1:0] entry_current,
	input  logic [VAL_W-1:0] entry_previous,
	input  logic             entry_readable,
	input  cfg_t             cfg,
	output result_t          res
);

	logic keep;

	always_comb begin
		case (cfg.recheck_mode)
			RECHK_EQ:  keep = vals_equal(entry_current, cfg.target, cfg.width_code);
			RECHK_CHG: keep = !vals_equal(entry_current, entry_previous, cfg.width_code);
			RECHK_GT:  keep = val_greater(entry_current, cfg.target, cfg.width_code);
			RECHK_LT:  keep = val_greater(cfg.target, entry_current, cfg.width_code);
			RECHK_INC: keep = val_greater(entry_current, entry_previous, cfg.width_code);
			RECHK_DEC: keep = val_greater(entry_previous, entry_current, cfg.width_code);
			default:   keep = 1'b0;
		endcase
		res.kind   = KIND_VERDICT;
		res.page   = '0;
		res.offset = '0;
		res.value  = '0;
		res.keep   = keep && entry_readable;
	end

endmodule

### sv/mvsf_out.sv
`timescale 1ns / 1ps
// result register with a skid stage between the scan logic and the output stream
module mvsf_out import mvsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  result_t     in_res,
	input  logic        out_ready,
	output logic        out_valid,
	output result_t     out_res,
	output buf_status_t status
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop               = out_valid_q && out_ready;
	assign out_valid         = out_valid_q;
	assign out_res           = out_q;
	assign status.out_valid  = out_valid_q;
	assign status.skid_valid = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= in_valid;
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || pop) begin
			if (in_valid) begin
				out_q <= in_res;
			end
		end else if (in_valid) begin
			skid_q <= in_res;
		end
	end

endmodule

### sv/memory_value_scan_filter.sv
`timescale 1ns / 1ps
// top level of the memory value scan filter
// One item is taken per clock cycle while s_tready is high: a scan item shifts
// one page byte into the 8-byte window and tests the candidate that it
// completes, a recheck item gives a keep or drop verdict for one stored entry.
// The window shift and the value compare are combinational between the scan
// state and the result register. Results pass through a two-deep result
// register and skid stage; s_tready falls only when both are full.
// Configuration goes through the apb port at byte address 8*index; the user
// must ensure it is written only while the block is idle; the block does not enforce this.
module memory_value_scan_filter import mvsf_pkg::*; #(
	parameter int PAGE_SIZE = PAGE_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// data_byte, page_base, entry_current, entry_previous, entry_readable, zero pad
	input  logic [207:0]          s_tdata,
	// command
	input  logic [0:0]            s_tuser,
	// end_of_page
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// match_page, match_offset, match_value, keep_entry, zero pad
	output logic [143:0]          m_tdata,
	// result_kind
	output logic [0:0]            m_tuser
);

	cfg_t        cfg;
	result_t     scan_res;
	result_t     rechk_res;
	result_t     res;
	result_t     out_res;
	buf_status_t status;
	logic        accept;
	logic        scan_acc;
	logic        found;
	logic        res_valid;
	logic        is_recheck;

	assign s_tready   = !status.skid_valid;
	assign accept     = s_tvalid && s_tready;
	assign is_recheck = s_tuser[0] == CMD_RECHECK;
	assign scan_acc   = accept && !is_recheck;
	assign res_valid  = accept && (is_recheck || found);
	assign res        = is_recheck ? rechk_res : scan_res;

	mvsf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mvsf_scan #(
		.PAGE_SIZE (PAGE_SIZE)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (scan_acc),
		.data_byte   (s_tdata[7:0]),
		.end_of_page (s_tlast),
		.page_base   (s_tdata[71:8]),
		.cfg         (cfg),
		.found       (found),
		.res         (scan_res)
	);

	mvsf_recheck u_recheck (
		.entry_current  (s_tdata[135:72]),
		.entry_previous (s_tdata[199:136]),
		.entry_readable (s_tdata[200]),
		.cfg            (cfg),
		.res            (rechk_res)
	);

	mvsf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.status    (status)
	);

	assign m_tdata = {3'b000, out_res.keep, out_res.value, out_res.offset, out_res.page};
	assign m_tuser = out_res.kind;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		status.skid_valid |-> status.out_valid)
		else $error("skid stage holds an item while the result register is empty");

	a_recheck_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_recheck && !m_tvalid) |=> (m_tvalid && m_tuser[0] == KIND_VERDICT))
		else $error("recheck item gave no verdict");

	a_verdict_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] == KIND_VERDICT) |-> (m_tdata[139:0] == '0))
		else $error("verdict carries match fields");

	a_match_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] == KIND_MATCH) |-> !m_tdata[140])
		else $error("match result carries a keep flag");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the memory value scan filter with stream driver, monitor and apb setup
module testbench;
	import mvsf_pkg::*;

	// short page so that overrunning pages stay cheap
	localparam int unsigned PAGE_BYTES = 128;
	localparam logic [1:0] INIT_NONE = 2'd3;
	localparam logic [2:0] RECHK_BAD6 = 3'd6;
	localparam logic [2:0] RECHK_BAD7 = 3'd7;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  data;
		logic        eop;
		logic [63:0] page;
		logic [63:0] cur;
		logic [63:0] prev;
		logic        readable;
	} mem_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [207:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic [0:0] m_tuser;

	// model state of the block
	cfg_t mdl_cfg;
	logic [63:0] win;
	logic [12:0] pos;
	logic [13:0] cand;

	mem_item_t items_to_send[$];
	result_t due_results[$];
	mem_item_t tx_item;
	mem_item_t in_item;
	result_t want_r;
	result_t got_r;
	int unsigned tx_gap;
	int unsigned rx_gap;
	bit tx_idle_on;
	bit rx_idle_on;
	logic [63:0] cur_page;
	int unsigned errors;
	int unsigned n_scans;
	int unsigned n_checks;
	int unsigned n_hits;
	int unsigned n_verdicts;

	memory_value_scan_filter #(
		.PAGE_SIZE(PAGE_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	function automatic logic signed [63:0] widen(input logic [63:0] v, input logic [1:0] code);
		int unsigned sh;
		sh = 64 - (8 << code);
		widen = $signed(v << sh) >>> sh;
	endfunction

	function automatic logic [63:0] lane_mask(input logic [1:0] code);
		lane_mask = {64{1'b1}} >> (64 - (8 << code));
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit filter_outcome(input mem_item_t it, output result_t r);
		int unsigned w;
		int unsigned step;
		int unsigned last;
		int unsigned p;
		logic [1:0] code;
		logic [63:0] v;
		bit hit;
		code = mdl_cfg.width_code;
		w = 1 << code;
		step = (mdl_cfg.scan_step == 0) ? 1 : 32'(mdl_cfg.scan_step);
		r = '0;
		hit = 1'b0;
		if (it.cmd == CMD_RECHECK) begin
			r.kind = KIND_VERDICT;
			if (it.readable) begin
				case (mdl_cfg.recheck_mode)
					RECHK_EQ:  r.keep = widen(it.cur, code) == widen(mdl_cfg.target, code);
					RECHK_CHG: r.keep = widen(it.cur, code) != widen(it.prev, code);
					RECHK_GT:  r.keep = widen(it.cur, code) > widen(mdl_cfg.target, code);
					RECHK_LT:  r.keep = widen(it.cur, code) < widen(mdl_cfg.target, code);
					RECHK_INC: r.keep = widen(it.cur, code) > widen(it.prev, code);
					RECHK_DEC: r.keep = widen(it.cur, code) < widen(it.prev, code);
					default:   r.keep = 1'b0;
				endcase
			end
			return 1'b1;
		end
		win = {it.data, win[63:8]};
		p = 32'(pos);
		last = 32'(cand) + w - 1;
		if (p > last) begin
			cand = 14'(p + 1);
		end else if (p == last) begin
			v = win >> (64 - 8 * w);
			case (mdl_cfg.initial_mode)
				INIT_EQ: hit = widen(v, code) == widen(mdl_cfg.target, code);
				INIT_GT: hit = widen(v, code) > widen(mdl_cfg.target, code);
				INIT_LT: hit = widen(v, code) < widen(mdl_cfg.target, code);
				default: hit = 1'b0;
			endcase
			if (hit) begin
				r.kind = KIND_MATCH;
				r.page = it.page;
				r.offset = cand[11:0];
				r.value = v;
				cand = 14'(32'(cand) + w + step);
			end else begin
				cand = 14'(32'(cand) + step);
			end
		end
		if (it.eop || p + 1 >= PAGE_BYTES) begin
			win = '0;
			pos = '0;
			cand = '0;
		end else begin
			pos = 13'(p + 1);
		end
		return hit;
	endfunction

	task automatic cmp_field(input string fname, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
			errors++;
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
			tx_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (tx_gap != 0) begin
				tx_gap <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (items_to_send.size() != 0) begin
				tx_item = items_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {7'd0, tx_item.readable, tx_item.prev, tx_item.cur, tx_item.page,
					tx_item.data};
				s_tuser <= tx_item.cmd;
				s_tlast <= tx_item.eop;
				tx_gap <= tx_idle_on ? idle_len() : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap <= 0;
		end else if (rx_gap != 0) begin
			m_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else begin
			m_tready <= 1'b1;
			rx_gap <= rx_idle_on ? idle_len() : 0;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				in_item.cmd = s_tuser[0];
				in_item.data = s_tdata[7:0];
				in_item.eop = s_tlast;
				in_item.page = s_tdata[71:8];
				in_item.cur = s_tdata[135:72];
				in_item.prev = s_tdata[199:136];
				in_item.readable = s_tdata[200];
				if (in_item.cmd == CMD_RECHECK)
					n_checks++;
				else
					n_scans++;
				if (filter_outcome(in_item, want_r))
					due_results.push_back(want_r);
			end
			if (m_tvalid && m_tready) begin
				got_r.kind = m_tuser[0];
				got_r.page = m_tdata[63:0];
				got_r.offset = m_tdata[75:64];
				got_r.value = m_tdata[139:76];
				got_r.keep = m_tdata[140];
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got_r);
					errors++;
				end else begin
					want_r = due_results.pop_front();
					cmp_field("result_kind", 64'(want_r.kind), 64'(got_r.kind));
					cmp_field("match_page", want_r.page, got_r.page);
					cmp_field("match_offset", 64'(want_r.offset), 64'(got_r.offset));
					cmp_field("match_value", want_r.value, got_r.value);
					cmp_field("keep_entry", 64'(want_r.keep), 64'(got_r.keep));
					if (want_r.kind == KIND_MATCH)
						n_hits++;
					else
						n_verdicts++;
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		logic [63:0] rd_want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WIDTH_CODE: begin
				mdl_cfg.width_code = val[1:0];
				rd_want = 64'(val[1:0]);
			end
			REG_TARGET: begin
				mdl_cfg.target = val;
				rd_want = val;
			end
			REG_INITIAL_MODE: begin
				mdl_cfg.initial_mode = val[1:0];
				rd_want = 64'(val[1:0]);
			end
			REG_RECHECK_MODE: begin
				mdl_cfg.recheck_mode = val[2:0];
				rd_want = 64'(val[2:0]);
			end
			REG_SCAN_STEP: begin
				mdl_cfg.scan_step = val[12:0];
				rd_want = 64'(val[12:0]);
			end
			default: rd_want = '0;
		endcase
		// read back the register just written
		@(negedge clk);
		if (pready !== 1'b1 || prdata !== rd_want) begin
			$display("%0t: register %0d readback mismatch, expected %h, actual %h", $time, idx,
				rd_want, prdata);
			errors++;
		end
	endtask

	task automatic set_all(input logic [1:0] wc, input logic [63:0] tgt, input logic [1:0] im,
			input logic [2:0] rm, input logic [12:0] step);
		write_reg(REG_WIDTH_CODE, 64'(wc));
		write_reg(REG_TARGET, tgt);
		write_reg(REG_INITIAL_MODE, 64'(im));
		write_reg(REG_RECHECK_MODE, 64'(rm));
		write_reg(REG_SCAN_STEP, 64'(step));
	endtask

	// wait until the block has nothing left in flight
	task automatic settle();
		while (items_to_send.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] data, input logic eop);
		mem_item_t it;
		it.cmd = CMD_SCAN;
		it.data = data;
		it.eop = eop;
		it.page = cur_page;
		it.cur = {$urandom, $urandom};
		it.prev = {$urandom, $urandom};
		it.readable = 1'($urandom_range(0, 1));
		items_to_send.push_back(it);
	endtask

	task automatic push_recheck(input logic [63:0] cur, input logic [63:0] prev, input logic rd);
		mem_item_t it;
		it.cmd = CMD_RECHECK;
		it.data = 8'($urandom);
		it.eop = 1'($urandom_range(0, 1));
		it.page = {$urandom, $urandom};
		it.cur = cur;
		it.prev = prev;
		it.readable = rd;
		items_to_send.push_back(it);
	endtask

	task automatic random_recheck();
		logic [63:0] m;
		logic [63:0] prev;
		logic [63:0] cur;
		m = lane_mask(mdl_cfg.width_code);
		prev = {$urandom, $urandom};
		cur = {$urandom, $urandom};
		case ($urandom_range(0, 6))
			0: cur = (cur & ~m) | (mdl_cfg.target & m);
			1: cur = (cur & ~m) | (prev & m);
			2: cur = prev + 64'd1;
			3: cur = prev - 64'd1;
			4: cur = mdl_cfg.target + 64'd1;
			5: cur = mdl_cfg.target - 64'd1;
			default: ;
		endcase
		push_recheck(cur, prev, $urandom_range(0, 4) != 0);
	endtask

	// page bytes built from copies of the target, near misses and random filler, with random rechecks mixed in
	task automatic random_page(input int unsigned len, input bit close);
		int unsigned n;
		int unsigned k;
		int unsigned w;
		int unsigned seg;
		int unsigned i;
		logic [63:0] pat;
		w = 1 << mdl_cfg.width_code;
		cur_page = {$urandom, $urandom};
		n = 0;
		while (n < len) begin
			k = $urandom_range(0, 9);
			if (k < 4)
				pat = mdl_cfg.target;
			else if (k == 4)
				pat = mdl_cfg.target + 64'd1;
			else if (k == 5)
				pat = mdl_cfg.target - 64'd1;
			else
				pat = {$urandom, $urandom};
			seg = (k < 6) ? w : $urandom_range(1, 9);
			for (i = 0; i < seg && n < len; i++) begin
				if ($urandom_range(0, 5) == 0)
					random_recheck();
				push_byte(pat[8 * (i % 8) +: 8], close && n == len - 1);
				n++;
			end
		end
	endtask

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int unsigned p;
		int unsigned sent;
		int unsigned len;
		int unsigned budget;
		bit close;
		logic [1:0] wc;
		logic [63:0] tgt;
		logic [63:0] m;
		logic [12:0] step;
		mdl_cfg.width_code = WIDTH_4B;
		mdl_cfg.target = '0;
		mdl_cfg.initial_mode = INIT_EQ;
		mdl_cfg.recheck_mode = RECHK_EQ;
		mdl_cfg.scan_step = 13'd1;
		win = '0;
		pos = '0;
		cand = '0;
		errors = 0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		cur_page = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// eight byte value against the most negative target, step zero, short page tail
		set_all(WIDTH_8B, 64'h8000_0000_0000_0000, INIT_GT, RECHK_CHG, 13'd0);
		cur_page = '1;
		repeat (8) push_byte(8'hff, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h12, 1'b0);
		push_byte(8'h34, 1'b1);
		push_recheck(64'd5, 64'd5, 1'b1);
		push_recheck(64'd1, 64'd0, 1'b0);
		push_recheck(64'd1, 64'd0, 1'b1);
		settle();

		// width shrinks in mid page so the pending candidate goes stale
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		set_all(WIDTH_8B, 64'd0, INIT_EQ, RECHK_BAD6, 13'd1);
		cur_page = '0;
		repeat (3) push_byte(8'h00, 1'b0);
		push_recheck(64'd0, 64'd0, 1'b1);
		settle();
		write_reg(REG_WIDTH_CODE, 64'(WIDTH_1B));
		write_reg(REG_INITIAL_MODE, 64'(INIT_LT));
		push_byte(8'h80, 1'b0);
		push_byte(8'h7f, 1'b0);
		push_byte(8'h80, 1'b1);
		settle();

		// unknown scan and recheck modes, a step of 4096
		set_all(WIDTH_2B, '1, INIT_NONE, RECHK_BAD7, 13'd4096);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b1);
		push_recheck('1, '1, 1'b1);
		settle();

		for (p = 0; p < 20; p++) begin
			wc = 2'($urandom_range(0, 3));
			m = lane_mask(wc);
			tgt = {$urandom, $urandom};
			case ($urandom_range(0, 5))
				0: tgt = '0;
				1: tgt = '1;
				2: tgt = (tgt & ~m) | ((m >> 1) + 64'd1);
				3: tgt = (tgt & ~m) | (m >> 1);
				default: ;
			endcase
			case ($urandom_range(0, 7))
				0: step = 13'd0;
				1, 2: step = 13'd1;
				3: step = 13'd2;
				4: step = 13'(1 << wc);
				5: step = 13'd4096;
				default: step = 13'($urandom_range(1, 12));
			endcase
			set_all(wc, tgt, 2'(p % 4), 3'(p % 8), step);
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			// a page that runs past the page size before its end marker
			if (p == 5 || p == 13)
				random_page(PAGE_BYTES + $urandom_range(1, 40), 1'b1);
			budget = 38;
			sent = 0;
			while (sent < budget) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 120) : $urandom_range(1, 48);
				if (len > budget - sent)
					len = budget - sent;
				close = (sent + len < budget) || ($urandom_range(0, 3) != 0);
				random_page(len, close);
				sent += len;
			end
			settle();
		end

		repeat (10) @(posedge clk);
		if (due_results.size() != 0)
			errors++;
		$display("covered %0d scan bytes and %0d rechecks over 24 register settings",
			n_scans, n_checks);
		$display("checked %0d matches and %0d recheck verdicts, %0d errors",
			n_hits, n_verdicts, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### memory_value_scan_filter.f
sv/mvsf_pkg.sv
sv/mvsf_cfg.sv
sv/mvsf_scan.sv
sv/mvsf_recheck.sv
sv/mvsf_out.sv
sv/memory_value_scan_filter.sv
bench/testbench.sv
